>>> rtl/core/svpwm_pkg.sv
// Shared types and constants for the space vector PWM duty block.
package svpwm_pkg;

   localparam int unsigned FIELD_WIDTH = 16;
   localparam int unsigned BUS_WIDTH = 15;
   localparam int unsigned PHASE_WIDTH = 33;
   localparam int unsigned MAG_WIDTH = 34;
   localparam int unsigned DIV_WIDTH = 16;
   localparam int unsigned NUM_PHASES = 3;

   localparam logic [PHASE_WIDTH-1:0] SQRT3_HALF_Q16 = 33'sd56756;
   localparam logic [FIELD_WIDTH-1:0] DUTY_HALF = 16'd32768;
   localparam logic [FIELD_WIDTH-1:0] DUTY_MIN = 16'd3277;
   localparam logic [FIELD_WIDTH-1:0] DUTY_MAX = 16'd62259;
   localparam logic [MAG_WIDTH-1:0] QUOT_LIMIT = 34'd29491;
   localparam logic [BUS_WIDTH-1:0] BUS_ONE_VOLT = 15'd256;

   typedef struct packed {
      logic [NUM_PHASES-1:0][DIV_WIDTH-1:0] rem;
      logic [NUM_PHASES-1:0][MAG_WIDTH-1:0] dq;
      logic [NUM_PHASES-1:0] neg;
      logic [DIV_WIDTH-1:0] divisor;
      logic low;
   } cell_data_type;

endpackage

>>> rtl/core/svpwm_front.sv
// Inverse Clarke transform and min-max offset, two registered stages.
module svpwm_front
   import svpwm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [FIELD_WIDTH-1:0] v_alpha,
   input  logic signed [FIELD_WIDTH-1:0] v_beta,
   input  logic [BUS_WIDTH-1:0] bus_voltage,
   output logic out_valid,
   input  logic out_ready,
   output cell_data_type out_data
);

   logic valid1_ff, valid1_in, valid2_ff, valid2_in;
   logic signed [NUM_PHASES-1:0][PHASE_WIDTH-1:0] v_ff, v_in;
   logic [DIV_WIDTH-1:0] div_ff, div_in;
   logic low_ff, low_in;
   cell_data_type data_ff, data_in;
   logic en1, en2;
   logic signed [PHASE_WIDTH-1:0] al_ext, be_ext, al_half, be_prod, va, vb, vc, vmax, vmin;
   logic signed [PHASE_WIDTH+1:0] sum_mm, n_val;

   assign en2 = !valid2_ff || out_ready;
   assign en1 = !valid1_ff || en2;
   assign in_ready = en1;
   assign out_valid = valid2_ff;
   assign out_data = data_ff;

   always_comb begin
      al_ext = PHASE_WIDTH'(v_alpha);
      be_ext = PHASE_WIDTH'(v_beta);
      al_half = al_ext <<< 15;
      be_prod = be_ext * $signed(SQRT3_HALF_Q16);
      v_in[0] = al_ext <<< 16;
      v_in[1] = be_prod - al_half;
      v_in[2] = -be_prod - al_half;
      div_in = {1'b0, bus_voltage} << 1;
      low_in = bus_voltage < BUS_ONE_VOLT;
      valid1_in = en1 ? in_valid : valid1_ff;
   end

   always_comb begin
      va = v_ff[0];
      vb = v_ff[1];
      vc = v_ff[2];
      vmax = va;
      if (vb > vmax) vmax = vb;
      if (vc > vmax) vmax = vc;
      vmin = va;
      if (vb < vmin) vmin = vb;
      if (vc < vmin) vmin = vc;
      sum_mm = (PHASE_WIDTH+2)'(vmax) + (PHASE_WIDTH+2)'(vmin);
      data_in.divisor = div_ff;
      data_in.low = low_ff;
      n_val = '0;
      for (int i = 0; i < NUM_PHASES; i++) begin
         n_val = ((PHASE_WIDTH+2)'($signed(v_ff[i])) <<< 1) - sum_mm;
         data_in.rem[i] = '0;
         data_in.neg[i] = n_val[PHASE_WIDTH+1];
         data_in.dq[i] = n_val[PHASE_WIDTH+1] ? MAG_WIDTH'(-n_val) : MAG_WIDTH'(n_val);
      end
      valid2_in = en2 ? valid1_ff : valid2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
      end
      if (en1) begin
         v_ff <= v_in;
         div_ff <= div_in;
         low_ff <= low_in;
      end
      if (en2) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> rtl/core/svpwm_div_cell.sv
// One restoring division step for all three phases, with its own stage register.
module svpwm_div_cell
   import svpwm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  cell_data_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output cell_data_type out_data
);

   logic valid_ff, valid_in;
   cell_data_type data_ff, data_in;
   logic [DIV_WIDTH:0] trial;
   logic en;

   assign en = !valid_ff || out_ready;
   assign in_ready = en;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_comb begin
      data_in = in_data;
      trial = '0;
      for (int i = 0; i < NUM_PHASES; i++) begin
         trial = {in_data.rem[i], in_data.dq[i][MAG_WIDTH-1]};
         if (trial >= {1'b0, in_data.divisor}) begin
            data_in.rem[i] = DIV_WIDTH'(trial - {1'b0, in_data.divisor});
            data_in.dq[i] = {in_data.dq[i][MAG_WIDTH-2:0], 1'b1};
         end else begin
            data_in.rem[i] = trial[DIV_WIDTH-1:0];
            data_in.dq[i] = {in_data.dq[i][MAG_WIDTH-2:0], 1'b0};
         end
      end
      valid_in = en ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> rtl/core/space_vector_pwm_duty.sv
// Top level of the space vector PWM duty generator.
//
// Channel | Direction | Contents
// req     | in        | v_alpha, v_beta, bus_voltage
// rsp     | out       | duty_a, duty_b, duty_c
//
// One transaction is accepted per cycle when not stalled.
// The chain of 34 division cells gives one quotient bit each.
// Reset clears the valid flags of every stage.
// A stall on rsp only holds stages that are full; empty stages keep filling.
module space_vector_pwm_duty
   import svpwm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [47:0] req_tdata, // v_alpha[15:0], v_beta[31:16], bus_voltage[46:32]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [47:0] rsp_tdata  // duty_a[15:0], duty_b[31:16], duty_c[47:32]
);

   logic [MAG_WIDTH:0] valid_chain, ready_chain;
   cell_data_type data_chain [MAG_WIDTH+1];
   logic out_valid_ff, out_valid_in, out_en;
   logic [NUM_PHASES-1:0][FIELD_WIDTH-1:0] duty_ff, duty_in;
   cell_data_type last;

   svpwm_front u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .v_alpha(req_tdata[15:0]),
      .v_beta(req_tdata[31:16]),
      .bus_voltage(req_tdata[46:32]),
      .out_valid(valid_chain[0]),
      .out_ready(ready_chain[0]),
      .out_data(data_chain[0])
   );

   for (genvar k = 0; k < MAG_WIDTH; k++) begin : g_cell
      svpwm_div_cell u_cell (
         .clock(clock),
         .reset(reset),
         .in_valid(valid_chain[k]),
         .in_ready(ready_chain[k]),
         .in_data(data_chain[k]),
         .out_valid(valid_chain[k+1]),
         .out_ready(ready_chain[k+1]),
         .out_data(data_chain[k+1])
      );
   end

   assign out_en = !out_valid_ff || rsp_tready;
   assign ready_chain[MAG_WIDTH] = out_en;
   assign last = data_chain[MAG_WIDTH];

   always_comb begin
      for (int i = 0; i < NUM_PHASES; i++) begin
         if (last.low) begin
            duty_in[i] = DUTY_HALF;
         end else if (last.dq[i] > QUOT_LIMIT) begin
            duty_in[i] = last.neg[i] ? DUTY_MIN : DUTY_MAX;
         end else if (last.neg[i]) begin
            duty_in[i] = DUTY_HALF - last.dq[i][FIELD_WIDTH-1:0];
         end else begin
            duty_in[i] = DUTY_HALF + last.dq[i][FIELD_WIDTH-1:0];
         end
      end
      out_valid_in = out_en ? valid_chain[MAG_WIDTH] : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (out_en) begin
         duty_ff <= duty_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = duty_ff;

endmodule

>>> tb/sv/tb_space_vector_pwm_duty.sv
// Self-checking testbench for the space vector PWM duty generator.
`timescale 1ns / 100ps

module tb_space_vector_pwm_duty;
   import svpwm_pkg::*;

   localparam int RESET_CYCLES = 9;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 60;
   localparam int RANDOM_ITEMS = 1520;

   typedef struct packed {
      logic [15:0] duty_c;
      logic [15:0] duty_b;
      logic [15:0] duty_a;
   } duty_set_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [47:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [47:0] rsp_tdata;

   duty_set_type expected_duties[$];
   int error_count;
   int idle_cycles;
   bit hold_rsp;
   bit stall_on;

   space_vector_pwm_duty DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] clamp_duty(longint n, longint bus);
      longint d;
      d = 32768 + n / (2 * bus);
      if (d < 3277) d = 3277;
      if (d > 62259) d = 62259;
      return d[15:0];
   endfunction

   function automatic duty_set_type predict_duties(logic [15:0] alpha, logic [15:0] beta,
                                                   logic [14:0] bus_raw);
      duty_set_type r;
      longint al, be, bus, va, vb, vc, vmax, vmin, s;
      al = longint'($signed(alpha));
      be = longint'($signed(beta));
      bus = longint'(bus_raw);
      if (bus < 256) begin
         r.duty_a = 16'd32768;
         r.duty_b = 16'd32768;
         r.duty_c = 16'd32768;
         return r;
      end
      va = al * 65536;
      vb = -al * 32768 + be * 56756;
      vc = -al * 32768 - be * 56756;
      vmax = va;
      if (vb > vmax) vmax = vb;
      if (vc > vmax) vmax = vc;
      vmin = va;
      if (vb < vmin) vmin = vb;
      if (vc < vmin) vmin = vc;
      s = vmax + vmin;
      r.duty_a = clamp_duty(2 * va - s, bus);
      r.duty_b = clamp_duty(2 * vb - s, bus);
      r.duty_c = clamp_duty(2 * vc - s, bus);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Sends one transaction and records its expected duties once accepted.
   task automatic send_vector(logic [15:0] alpha, logic [15:0] beta, logic [14:0] bus);
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, bus, beta, alpha};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_duties.push_back(predict_duties(alpha, beta, bus));
   endtask

   task automatic pause_sender(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_duties.size() != 0) @(posedge clock);
   endtask

   function automatic logic [14:0] random_bus();
      case ($urandom_range(0, 5))
         0: return 15'($urandom_range(0, 255));
         1: return 15'($urandom_range(256, 600));
         2: return 15'($urandom_range(32000, 32767));
         default: return 15'($urandom_range(256, 32767));
      endcase
   endfunction

   task automatic test_directed();
      send_vector(16'h0000, 16'h0000, 15'd0);
      send_vector(16'h7FFF, 16'h7FFF, 15'd255);
      send_vector(16'h7FFF, 16'h0000, 15'd256);
      send_vector(16'h8000, 16'h0000, 15'd256);
      send_vector(16'h0000, 16'h7FFF, 15'd256);
      send_vector(16'h0000, 16'h8000, 15'd256);
      send_vector(16'h8000, 16'h8000, 15'd32767);
      send_vector(16'h7FFF, 16'h8000, 15'd32767);
      send_vector(16'h8000, 16'h7FFF, 15'h7FFF);
      send_vector(16'hFFFF, 16'hFFFF, 15'd256);
      send_vector(16'h0001, 16'h0001, 15'd257);
      send_vector(16'd3000, 16'd1200, 15'd6144);
      send_vector(16'hF000, 16'h0800, 15'd6144);
      send_vector(16'h5555, 16'hAAAA, 15'h2AAA);
      send_vector(16'hAAAA, 16'h5555, 15'h5555);
      wait_drained();
   endtask

   task automatic test_random();
      int burst;
      for (int i = 0; i < RANDOM_ITEMS; ) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && i < RANDOM_ITEMS; k++, i++) begin
            if ($urandom_range(0, 3) == 0)
               send_vector(16'($urandom_range(0, 65535)) & 16'h00FF,
                           16'($urandom_range(0, 65535)) & 16'h00FF, random_bus());
            else
               send_vector(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           random_bus());
         end
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
      end
      wait_drained();
   endtask

   // The receiver holds off long enough for the pipeline to fill and back up.
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      for (int i = 0; i < 60; i++)
         send_vector(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     random_bus());
      wait_drained();
   endtask

   initial begin
      int held;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            held = 0;
            while (held < 200) begin
               @(posedge clock);
               held++;
            end
            hold_rsp = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_on <= 1'b0;
      end else begin
         if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
         rsp_tready <= !hold_rsp && !(stall_on && $urandom_range(0, 1) == 0);
      end
   end

   always @(posedge clock) begin
      duty_set_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_duties.size() == 0) begin
            report_mismatch("unexpected transaction", 0, 0);
         end else begin
            want = expected_duties.pop_front();
            if (got.duty_a !== want.duty_a) report_mismatch("duty_a", got.duty_a, want.duty_a);
            if (got.duty_b !== want.duty_b) report_mismatch("duty_b", got.duty_b, want.duty_b);
            if (got.duty_c !== want.duty_c) report_mismatch("duty_c", got.duty_c, want.duty_c);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      idle_cycles = 0;
      hold_rsp = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_duties.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/svpwm_pkg.sv
rtl/core/svpwm_front.sv
rtl/core/svpwm_div_cell.sv
rtl/core/space_vector_pwm_duty.sv
tb/sv/tb_space_vector_pwm_duty.sv
